// ----- hw/rtl/psu_pkg.sv -----
package psu_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int WIDTH_W   = 13;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [WIDTH_W-1:0]   WIDTH_RESET     = WIDTH_W'(640);
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = REG_IDX_W'(0);

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // neighbors of one channel as seen by a lane
  typedef struct packed {
    logic [CH_W-1:0] left;
    logic [CH_W-1:0] up;
    logic [CH_W-1:0] up_left;
  } nbr_t;

endpackage

// ----- hw/rtl/psu_ram.sv -----
module psu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/psu_lane.sv -----
// one color channel: predictor select plus add, mod 256
module psu_lane (
  input  psu_pkg::filt_t             filt,
  input  logic [psu_pkg::CH_W-1:0]   raw,
  input  psu_pkg::nbr_t              nbr,
  output logic [psu_pkg::CH_W-1:0]   recon
);

  logic [psu_pkg::CH_W:0]   avg_sum;
  logic signed [9:0]        d_pa;
  logic signed [9:0]        d_pb;
  logic signed [9:0]        d_pc;
  logic [9:0]               pa;
  logic [9:0]               pb;
  logic [9:0]               pc;
  logic [psu_pkg::CH_W-1:0] paeth;
  logic [psu_pkg::CH_W-1:0] pred;

  assign avg_sum = {1'b0, nbr.left} + {1'b0, nbr.up};

  // p = a + b - c, so p-a = b-c, p-b = a-c, p-c = a+b-2c
  assign d_pa = $signed({2'b00, nbr.up}) - $signed({2'b00, nbr.up_left});
  assign d_pb = $signed({2'b00, nbr.left}) - $signed({2'b00, nbr.up_left});
  assign d_pc = $signed({2'b00, nbr.left}) + $signed({2'b00, nbr.up})
              - $signed({1'b0, nbr.up_left, 1'b0});

  assign pa = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
  assign pb = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
  assign pc = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);

  always_comb begin
    if (pa <= pb && pa <= pc) begin
      paeth = nbr.left;
    end else if (pb <= pc) begin
      paeth = nbr.up;
    end else begin
      paeth = nbr.up_left;
    end
  end

  always_comb begin
    unique case (filt)
      psu_pkg::FILT_NONE:  pred = '0;
      psu_pkg::FILT_SUB:   pred = nbr.left;
      psu_pkg::FILT_UP:    pred = nbr.up;
      psu_pkg::FILT_AVG:   pred = avg_sum[psu_pkg::CH_W:1];
      psu_pkg::FILT_PAETH: pred = paeth;
      default:             pred = '0;  // codes 5..7 pass raw
    endcase
  end

  assign recon = raw + pred;

endmodule

// ----- hw/rtl/png_scanline_unfilter_rgb8_core.sv -----
// PNG filter reconstruction, 8-bit RGB, one pixel per beat.
// Input channel (in_valid/in_ready): start_of_image, filter_type and the
// three filtered bytes. Output channel (out_valid/out_ready): reconstructed
// bytes plus end_of_row on the last pixel of each row.
// Config: APB write of image_width at byte address 0 (0 acts as 1, above
// 4096 clamps to 4096); change it only while the block is idle.
// Throughput: one pixel per clock while out_ready keeps the output register
// draining, set by the left-pixel feedback through the three channel lanes
// and one line-buffer port pair. From input accept to out_valid: line-buffer
// read into stage 1, then reconstruction into the output register.
// Reset (rst, synchronous): column 0, first row, left/up-left zero, output
// empty, image_width = 640. The line buffer is not cleared; the first row
// never uses its contents.
// Receiver stall: the output register holds its beat, the reconstruct stage
// holds one more pixel, then in_ready drops; nothing is dropped.
module png_scanline_unfilter_rgb8_core (
  input  logic                          clk,
  input  logic                          rst,
  // pixel in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_of_image,
  input  logic [2:0]                    filter_type,
  input  logic [7:0]                    raw_red,
  input  logic [7:0]                    raw_green,
  input  logic [7:0]                    raw_blue,
  // pixel out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic                          end_of_row,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psu_pkg::PADDR_W-1:0]   paddr,
  input  logic [psu_pkg::DATA_W-1:0]    pwdata,
  output logic [psu_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // ---------------- config register ----------------
  logic [psu_pkg::WIDTH_W-1:0] image_width;
  logic [psu_pkg::CNT_W-1:0]   width_eff;
  logic                        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[psu_pkg::PADDR_W-1:2] == psu_pkg::REG_IMAGE_WIDTH);
  assign prdata  = reg_hit ? psu_pkg::DATA_W'(image_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= psu_pkg::WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      image_width <= pwdata[psu_pkg::WIDTH_W-1:0];
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = psu_pkg::CNT_W'(1);
    end else if (int'(image_width) > psu_pkg::MAX_WIDTH) begin
      width_eff = psu_pkg::CNT_W'(psu_pkg::MAX_WIDTH);
    end else begin
      width_eff = psu_pkg::CNT_W'(image_width);
    end
  end

  // ---------------- stage 0: position tracking, line-buffer read --------
  // Column/row bookkeeping does not depend on pixel data, so it runs at
  // accept time and the line-buffer address is issued right away.
  logic                      accept;
  logic [psu_pkg::COL_W-1:0] column_count;
  logic                      first_row_flag;
  logic [psu_pkg::COL_W-1:0] col_in;
  logic                      first_in;
  logic                      last_in;

  assign accept   = in_valid && in_ready;
  assign col_in   = start_of_image ? '0 : column_count;
  assign first_in = start_of_image || first_row_flag;
  assign last_in  = (psu_pkg::CNT_W'(col_in) + psu_pkg::CNT_W'(1)) >= width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      first_row_flag <= 1'b1;
    end else if (accept) begin
      if (last_in) begin
        column_count   <= '0;
        first_row_flag <= 1'b0;
      end else begin
        column_count   <= col_in + psu_pkg::COL_W'(1);
        first_row_flag <= first_in;
      end
    end
  end

  // ---------------- stage 1: lanes ----------------
  logic                      s1_valid;
  logic                      s1_go;
  logic                      s1_start;
  logic                      s1_first;
  logic                      s1_last;
  logic                      s1_fwd;
  logic [psu_pkg::COL_W-1:0] s1_col;
  psu_pkg::filt_t            s1_filt;
  logic [psu_pkg::PIX_W-1:0] s1_raw;

  logic [psu_pkg::PIX_W-1:0] left_pixel;
  logic [psu_pkg::PIX_W-1:0] up_left_pixel;
  logic [psu_pkg::PIX_W-1:0] last_wr;    // last pixel written to line buffer
  logic [psu_pkg::PIX_W-1:0] ram_q;
  logic [psu_pkg::PIX_W-1:0] up_pix;
  logic [psu_pkg::PIX_W-1:0] a_pix;
  logic [psu_pkg::PIX_W-1:0] c_pix;
  logic [psu_pkg::PIX_W-1:0] recon;

  // output register takes a beat when empty or being drained
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= start_of_image;
      s1_first <= first_in;
      s1_last  <= last_in;
      s1_col   <= col_in;
      s1_filt  <= psu_pkg::filt_t'(filter_type);
      s1_raw   <= {raw_blue, raw_green, raw_red};
      // same-column write in this very cycle (one-pixel rows): RAM read is
      // stale, take the written pixel instead
      s1_fwd   <= s1_go && (s1_col == col_in);
    end
  end

  psu_ram #(
    .WIDTH (psu_pkg::PIX_W),
    .DEPTH (psu_pkg::MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata (recon),
    .re    (accept),
    .raddr (col_in),
    .rdata (ram_q)
  );

  always_comb begin
    priority if (s1_first) begin
      up_pix = '0;
    end else if (s1_fwd) begin
      up_pix = last_wr;
    end else begin
      up_pix = ram_q;
    end
  end

  assign a_pix = s1_start ? '0 : left_pixel;
  assign c_pix = s1_start ? '0 : up_left_pixel;

  for (genvar k = 0; k < psu_pkg::NUM_CH; k++) begin : g_lane
    psu_pkg::nbr_t nbr;
    assign nbr.left    = a_pix[k*psu_pkg::CH_W +: psu_pkg::CH_W];
    assign nbr.up      = up_pix[k*psu_pkg::CH_W +: psu_pkg::CH_W];
    assign nbr.up_left = c_pix[k*psu_pkg::CH_W +: psu_pkg::CH_W];

    psu_lane u_lane (
      .filt  (s1_filt),
      .raw   (s1_raw[k*psu_pkg::CH_W +: psu_pkg::CH_W]),
      .nbr   (nbr),
      .recon (recon[k*psu_pkg::CH_W +: psu_pkg::CH_W])
    );
  end

  // left / up-left neighbors follow the reconstructed stream
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel    <= '0;
      up_left_pixel <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        left_pixel    <= '0;
        up_left_pixel <= '0;
      end else begin
        left_pixel    <= recon;
        up_left_pixel <= up_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      last_wr <= recon;
    end
  end

  // ---------------- merge: output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_red    <= recon[0*psu_pkg::CH_W +: psu_pkg::CH_W];
      out_green  <= recon[1*psu_pkg::CH_W +: psu_pkg::CH_W];
      out_blue   <= recon[2*psu_pkg::CH_W +: psu_pkg::CH_W];
      end_of_row <= s1_last;
    end
  end

`ifndef SYNTH
  // a row end clears the neighbor registers
  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> left_pixel == '0 && up_left_pixel == '0)
    else $error("left/up-left not cleared after row end");

  // start of image lands in stage 1 as column 0 of a first row
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && start_of_image |=> s1_valid && s1_first && s1_col == '0)
    else $error("start_of_image not mapped to column 0, first row");

  // a stalled pixel in stage 1 keeps its column and row flags
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_col) && $stable(s1_last))
    else $error("stage 1 pixel changed while stalled");
`endif

endmodule
